// ===== src/canonical_huffman_table_engine_assert.svh =====
// Assertion macros for the canonical Huffman table engine.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef CANONICAL_HUFFMAN_TABLE_ENGINE_ASSERT_SVH
`define CANONICAL_HUFFMAN_TABLE_ENGINE_ASSERT_SVH

// checked only outside reset
`define CHTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define CHTE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/chte_pkg.sv =====
// Shared types and constants for the canonical Huffman table engine.
// No dependencies; imported by chte_build, chte_tables and the top level.
package chte_pkg;

    localparam logic [1:0] OP_WRITE_LEN = 2'd0;
    localparam logic [1:0] OP_BUILD     = 2'd1;
    localparam logic [1:0] OP_DECODE    = 2'd2;
    localparam logic [1:0] OP_ENCODE    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_NO_TABLE = 2'd2;

    localparam logic [1:0] REG_TABLE_BITS   = 2'd0;
    localparam logic [1:0] REG_SYMBOL_COUNT = 2'd1;
    localparam logic [1:0] REG_ENTRY_KIND   = 2'd2;

    localparam logic [8:0] LEN_MODE_SYMBOLS = 9'd28;
    localparam logic [3:0] LEN_BASE_SHIFT   = 4'd12;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  symbol;
        logic [3:0]  code_len;
        logic [29:0] bit_window;
    } chte_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] code_bits;
        logic [3:0]  code_length;
        logic [15:0] decoded_value;
        logic [4:0]  consumed_bits;
    } chte_out_t;

    // table store write requests from the build sequencer
    typedef struct packed {
        logic        enc_we;
        logic [7:0]  enc_addr;
        logic [18:0] enc_data;
        logic        dec_we;
        logic [14:0] dec_addr;
        logic [23:0] dec_data;
    } tbl_wr_t;

    typedef struct packed {
        logic done;
        logic ok;
    } bld_stat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CHECK,
        B_SCAN_RD,
        B_SCAN_EV,
        B_KRAFT,
        B_KCHK,
        B_NEXT,
        B_ASSIGN_RD,
        B_ASSIGN_EV,
        B_FILL,
        B_DONE
    } bld_state_t;

    function automatic logic [14:0] bit_flip(input logic [14:0] code, input logic [3:0] len);
        logic [14:0] r;
        int          j;
        r = '0;
        for (int i = 0; i < 15; i++)
        begin
            j = int'(len) - 1 - i;
            if (i < int'(len) && j >= 0)
            begin
                r[j] = code[i];
            end
        end
        return r;
    endfunction

endpackage

// ===== src/chte_build.sv =====
// Build sequencer: length store, histogram, Kraft check, next-code table, store fill.
// Depends on chte_pkg.
module chte_build #(
    parameter int MAX_SYMBOLS    = 256,
    parameter int MAX_TABLE_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           len_we,
    input  logic [$clog2(MAX_SYMBOLS)-1:0] len_addr,
    input  logic [3:0]                     len_data,
    input  logic                           go,
    input  logic [3:0]                     table_bits,
    input  logic [8:0]                     sym_count,
    input  logic                           entry_kind,
    output logic                           busy,
    output chte_pkg::bld_stat_t            stat,
    output chte_pkg::tbl_wr_t              wr
);
    import chte_pkg::*;

    localparam int         SYM_W  = $clog2(MAX_SYMBOLS);
    localparam logic [4:0] TB_MAX = 5'(MAX_TABLE_BITS);

    logic [3:0]             lmem [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] lv_reg;
    logic [3:0]             rd_q;
    logic                   rv_q;
    logic [3:0]             cur_len;

    bld_state_t  state_reg, state_next;
    logic [8:0]  cnt_reg, cnt_next, cnt_inc;
    logic [3:0]  lcnt_reg, lcnt_next;
    logic [23:0] kraft_reg, kraft_next;
    logic [16:0] c_reg, c_next, c_new;
    logic        used_reg, used_next;
    logic        ok_reg, ok_next;
    logic [15:0] fill_reg, fill_next, fill_sum;
    logic [15:0] step_reg, step_next;
    logic [23:0] ent_reg, ent_next;
    logic [8:0]  hist_reg [16];
    logic [8:0]  hist_next [16];
    logic [15:0] nc_reg [16];
    logic [15:0] nc_next [16];

    logic [15:0] size;
    logic [14:0] flip;
    logic [3:0]  sh;
    logic [15:0] base;
    logic [3:0]  xbits;

    // length store: one write port from the item side, one read port for the sequencer
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            lmem[len_addr] <= len_data;
        end
        rd_q <= lmem[cnt_reg[SYM_W-1:0]];
    end

    // per-entry valid bits give the all-zero reset of the length store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg <= '0;
            rv_q   <= 1'b0;
        end
        else
        begin
            if (len_we)
            begin
                lv_reg[len_addr] <= 1'b1;
            end
            rv_q <= lv_reg[cnt_reg[SYM_W-1:0]];
        end
    end

    assign cur_len = rv_q ? rd_q : 4'd0;
    assign size    = 16'(1) << table_bits;
    assign cnt_inc = cnt_reg + 9'd1;
    assign flip    = bit_flip(nc_reg[cur_len][14:0], cur_len) & 15'(size - 16'd1);
    assign fill_sum = fill_reg + step_reg;
    assign c_new   = 17'((c_reg + ((lcnt_reg == 4'd1) ? 17'd0
                         : 17'(hist_reg[lcnt_reg - 4'd1]))) << 1);
    assign sh      = cnt_reg[3:0] - LEN_BASE_SHIFT;

    always_comb
    begin
        if (!entry_kind || cnt_reg < 9'd16)
        begin
            base  = 16'(cnt_reg);
            xbits = 4'd0;
        end
        else
        begin
            base  = 16'(1) << sh;
            xbits = sh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ok_reg    <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        lcnt_reg  <= lcnt_next;
        kraft_reg <= kraft_next;
        c_reg     <= c_next;
        used_reg  <= used_next;
        fill_reg  <= fill_next;
        step_reg  <= step_next;
        ent_reg   <= ent_next;
        nc_reg    <= nc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lcnt_next  = lcnt_reg;
        kraft_next = kraft_reg;
        c_next     = c_reg;
        used_next  = used_reg;
        ok_next    = ok_reg;
        fill_next  = fill_reg;
        step_next  = step_reg;
        ent_next   = ent_reg;
        hist_next  = hist_reg;
        nc_next    = nc_reg;
        wr         = '0;
        stat       = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (go)
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (table_bits == 4'd0 || {1'b0, table_bits} > TB_MAX || sym_count == 9'd0
                    || (entry_kind && sym_count > LEN_MODE_SYMBOLS))
                begin
                    ok_next    = 1'b0;
                    state_next = B_DONE;
                end
                else
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        hist_next[i] = '0;
                    end
                    cnt_next   = '0;
                    used_next  = 1'b0;
                    state_next = B_SCAN_RD;
                end
            end
            B_SCAN_RD:
            begin
                state_next = B_SCAN_EV;
            end
            B_SCAN_EV:
            begin
                if (cur_len > table_bits)
                begin
                    ok_next    = 1'b0;
                    state_next = B_DONE;
                end
                else
                begin
                    hist_next[cur_len] = hist_reg[cur_len] + 9'd1;
                    if (cur_len != 4'd0)
                    begin
                        used_next = 1'b1;
                    end
                    cnt_next = cnt_inc;
                    if (cnt_inc == sym_count)
                    begin
                        lcnt_next  = 4'd1;
                        kraft_next = '0;
                        state_next = B_KRAFT;
                    end
                    else
                    begin
                        state_next = B_SCAN_RD;
                    end
                end
            end
            B_KRAFT:
            begin
                kraft_next = kraft_reg + (24'(hist_reg[lcnt_reg]) << (table_bits - lcnt_reg));
                lcnt_next  = lcnt_reg + 4'd1;
                if (lcnt_reg == table_bits)
                begin
                    state_next = B_KCHK;
                end
            end
            B_KCHK:
            begin
                if (kraft_reg != 24'(size) || !used_reg)
                begin
                    ok_next    = 1'b0;
                    state_next = B_DONE;
                end
                else
                begin
                    c_next     = '0;
                    lcnt_next  = 4'd1;
                    state_next = B_NEXT;
                end
            end
            B_NEXT:
            begin
                nc_next[lcnt_reg] = c_new[15:0];
                c_next            = c_new;
                lcnt_next         = lcnt_reg + 4'd1;
                if (lcnt_reg == table_bits)
                begin
                    cnt_next   = '0;
                    state_next = B_ASSIGN_RD;
                end
            end
            B_ASSIGN_RD:
            begin
                state_next = B_ASSIGN_EV;
            end
            B_ASSIGN_EV:
            begin
                wr.enc_we   = 1'b1;
                wr.enc_addr = cnt_reg[7:0];
                wr.enc_data = (cur_len == 4'd0) ? 19'd0 : {cur_len, flip};
                if (cur_len != 4'd0)
                begin
                    nc_next[cur_len] = nc_reg[cur_len] + 16'd1;
                    fill_next        = 16'(flip);
                    step_next        = 16'(1) << cur_len;
                    ent_next         = {base, xbits, cur_len};
                    state_next       = B_FILL;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == sym_count)
                    begin
                        ok_next    = 1'b1;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        state_next = B_ASSIGN_RD;
                    end
                end
            end
            B_FILL:
            begin
                // replicate the entry over every slot whose low bits match the code
                wr.dec_we   = 1'b1;
                wr.dec_addr = fill_reg[14:0];
                wr.dec_data = ent_reg;
                fill_next   = fill_sum;
                if (fill_sum >= size)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == sym_count)
                    begin
                        ok_next    = 1'b1;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        state_next = B_ASSIGN_RD;
                    end
                end
            end
            B_DONE:
            begin
                stat.done  = 1'b1;
                stat.ok    = ok_reg;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != B_IDLE);

endmodule

// ===== src/chte_tables.sv =====
// Encode and decode stores: one write port from the build sequencer, registered lookup reads.
// Depends on chte_pkg.
module chte_tables #(
    parameter int MAX_SYMBOLS    = 256,
    parameter int MAX_TABLE_BITS = 15
) (
    input  logic                           clk,
    input  chte_pkg::tbl_wr_t              wr,
    input  logic [$clog2(MAX_SYMBOLS)-1:0] enc_raddr,
    input  logic [MAX_TABLE_BITS-1:0]      dec_raddr,
    output logic [18:0]                    enc_q,
    output logic [23:0]                    dec_q
);
    import chte_pkg::*;

    localparam int SYM_W = $clog2(MAX_SYMBOLS);

    logic [18:0] enc_mem [MAX_SYMBOLS];
    logic [23:0] dec_mem [2**MAX_TABLE_BITS];

    always_ff @(posedge clk)
    begin
        if (wr.enc_we)
        begin
            enc_mem[wr.enc_addr[SYM_W-1:0]] <= wr.enc_data;
        end
        enc_q <= enc_mem[enc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.dec_we)
        begin
            dec_mem[wr.dec_addr[MAX_TABLE_BITS-1:0]] <= wr.dec_data;
        end
        dec_q <= dec_mem[dec_raddr];
    end

endmodule

// ===== src/canonical_huffman_table_engine.sv =====
// Top level of the canonical Huffman table engine: register port, item stage, result register.
// Depends on chte_pkg, chte_build, chte_tables and canonical_huffman_table_engine_assert.svh.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------
//  item in   | start, busy           | in (chte_in_t)
//  result    | done (one cycle)      | result (chte_out_t)
//  registers | psel, penable, pwrite | paddr, pwdata, prdata, pready=1
//
// Length writes, encode and decode lookups: one item per cycle while no build is running; the
// store read is registered in the item stage, then the result register drives result and done.
// Build: busy until it finishes, ending early when rejected: a read and an evaluate state per symbol
// in each of the scan and assign walks over the length store, a step per length in the Kraft and
// next-code passes, and a write per decode slot filled.
// No clearing pass after reset; the result side cannot stall.
module canonical_huffman_table_engine #(
    parameter int MAX_SYMBOLS    = 256,
    parameter int MAX_TABLE_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  chte_pkg::chte_in_t in,
    output logic               done,
    output chte_pkg::chte_out_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import chte_pkg::*;

    localparam int         SYM_W        = $clog2(MAX_SYMBOLS);
    localparam logic [8:0] SYM_MAX      = 9'(MAX_SYMBOLS);
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic [3:0]  tb_reg;
    logic [8:0]  sc_reg;
    logic        ek_reg;
    logic        valid_reg;
    logic [8:0]  n_sat;
    logic        cfg_wr;
    logic        accept;
    logic        len_we;
    logic        bld_busy;
    bld_stat_t   bld_stat;
    tbl_wr_t     tbl_wr;
    logic [18:0] enc_q;
    logic [23:0] dec_q;
    logic [15:0] idx_mask;

    logic        s1_v_reg;
    logic [1:0]  s1_op_reg;
    logic        s1_nov_reg;
    logic        s1_encok_reg;
    logic [29:0] s1_win_reg;

    chte_out_t   res_reg, res_next;
    logic        done_reg, done_next;

    logic [3:0]  d_len, d_x;
    logic [29:0] d_sh;
    logic [15:0] d_extra;

    assign n_sat  = (sc_reg > SYM_MAX) ? SYM_MAX : sc_reg;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign accept = start && !bld_busy;
    assign busy   = bld_busy;
    assign len_we = accept && in.opcode == OP_WRITE_LEN && {1'b0, in.symbol} < SYM_MAX;
    assign idx_mask = (16'(1) << tb_reg) - 16'd1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TABLE_BITS:   prdata = {28'd0, tb_reg};
            REG_SYMBOL_COUNT: prdata = {23'd0, sc_reg};
            REG_ENTRY_KIND:   prdata = {31'd0, ek_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tb_reg    <= 4'd9;
            sc_reg    <= 9'd256;
            ek_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_TABLE_BITS:   tb_reg <= pwdata[3:0];
                    REG_SYMBOL_COUNT: sc_reg <= pwdata[8:0];
                    REG_ENTRY_KIND:   ek_reg <= pwdata[0];
                    default:          ;
                endcase
            end
            priority if (cfg_wr && paddr[3:2] != REG_UNMAPPED)
            begin
                valid_reg <= 1'b0;
            end
            else if (len_we || (accept && in.opcode == OP_BUILD))
            begin
                valid_reg <= 1'b0;
            end
            else if (bld_stat.done)
            begin
                valid_reg <= bld_stat.ok;
            end
        end
    end

    chte_build #(
        .MAX_SYMBOLS    (MAX_SYMBOLS),
        .MAX_TABLE_BITS (MAX_TABLE_BITS)
    ) u_build (
        .clk        (clk),
        .rst_n      (rst_n),
        .len_we     (len_we),
        .len_addr   (in.symbol[SYM_W-1:0]),
        .len_data   (in.code_len),
        .go         (accept && in.opcode == OP_BUILD),
        .table_bits (tb_reg),
        .sym_count  (n_sat),
        .entry_kind (ek_reg),
        .busy       (bld_busy),
        .stat       (bld_stat),
        .wr         (tbl_wr)
    );

    chte_tables #(
        .MAX_SYMBOLS    (MAX_SYMBOLS),
        .MAX_TABLE_BITS (MAX_TABLE_BITS)
    ) u_tables (
        .clk       (clk),
        .wr        (tbl_wr),
        .enc_raddr (in.symbol[SYM_W-1:0]),
        .dec_raddr (in.bit_window[MAX_TABLE_BITS-1:0] & idx_mask[MAX_TABLE_BITS-1:0]),
        .enc_q     (enc_q),
        .dec_q     (dec_q)
    );

    // item stage: waits out the store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept && in.opcode != OP_BUILD;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= in.opcode;
        s1_nov_reg   <= !valid_reg;
        s1_encok_reg <= {1'b0, in.symbol} < n_sat;
        s1_win_reg   <= in.bit_window;
        res_reg      <= res_next;
    end

    assign d_len   = dec_q[3:0];
    assign d_x     = dec_q[7:4];
    assign d_sh    = s1_win_reg >> d_len;
    assign d_extra = d_sh[15:0] & ((16'(1) << d_x) - 16'd1);

    always_comb
    begin
        res_next  = '0;
        done_next = 1'b0;
        if (bld_stat.done)
        begin
            done_next       = 1'b1;
            res_next.status = bld_stat.ok ? ST_OK : ST_REJECTED;
        end
        else if (s1_v_reg)
        begin
            done_next = 1'b1;
            if (s1_op_reg != OP_WRITE_LEN)
            begin
                priority if (s1_nov_reg)
                begin
                    res_next.status = ST_NO_TABLE;
                end
                else if (s1_op_reg == OP_DECODE)
                begin
                    res_next.code_length   = d_len;
                    res_next.decoded_value = dec_q[23:8] + d_extra;
                    res_next.consumed_bits = {1'b0, d_len} + {1'b0, d_x};
                end
                else if (s1_encok_reg)
                begin
                    res_next.code_bits   = enc_q[14:0];
                    res_next.code_length = enc_q[18:15];
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

`include "canonical_huffman_table_engine_assert.svh"

    `CHTE_ASSERT(a_build_done_alone, bld_stat.done |-> !s1_v_reg, "build result collides with lookup")
    `CHTE_ASSERT(a_stage_delivers, s1_v_reg |=> done_reg, "staged item lost its result")
    `CHTE_ASSERT(a_valid_from_build,
        $rose(valid_reg) |-> $past(bld_stat.done && bld_stat.ok), "table valid without build")
    `CHTE_ASSERT_ALWAYS(a_no_build_start_busy, !(bld_busy && accept), "item accepted while building")

endmodule

// ===== tb/canonical_huffman_table_engine_tb.sv =====
// Self-checking testbench for canonical_huffman_table_engine: length writes, builds and lookups.
// Depends on chte_pkg and the RTL top level; predicts each result and checks it as it arrives.
module canonical_huffman_table_engine_tb;

    import chte_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    chte_in_t    in;
    logic        done;
    chte_out_t   result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    canonical_huffman_table_engine DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in      (in),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block's state
    logic [3:0]  tbl_bits;
    logic [8:0]  sym_cnt;
    logic        len_kind;
    logic [3:0]  len_mem [256];
    logic [18:0] enc_mem [256];
    logic [23:0] dec_mem [32768];
    logic        tbl_ok;

    chte_out_t   expected_results [$];
    int          errors;
    int          items_sent;
    bit          calm;
    int          plan_len [256];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int alphabet_size();
        return (sym_cnt > 9'd256) ? 256 : int'(sym_cnt);
    endfunction

    function automatic logic [14:0] reverse_code(int code, int len);
        logic [14:0] r;
        r = '0;
        for (int i = 0; i < len; i++)
        begin
            r[len - 1 - i] = code[i];
        end
        return r;
    endfunction

    function automatic logic [23:0] slot_entry(int s, int len);
        logic [23:0] e;
        if (!len_kind || s < 16)
        begin
            e = 24'(s) << 8;
        end
        else
        begin
            e = (24'(1) << (s - 12 + 8)) | (24'(s - 12) << 4);
        end
        return e | 24'(len);
    endfunction

    function automatic bit build_tables();
        int n;
        int b;
        int hist [16];
        int nxt [16];
        int used;
        int kraft;
        int size;
        int c;
        int l;
        int r;
        n = alphabet_size();
        b = int'(tbl_bits);
        used = 0;
        kraft = 0;
        c = 0;
        if (b == 0)
        begin
            return 1'b0;
        end
        if (len_kind && n > 28)
        begin
            return 1'b0;
        end
        for (int i = 0; i < 16; i++)
        begin
            hist[i] = 0;
        end
        for (int s = 0; s < n; s++)
        begin
            l = int'(len_mem[s]);
            if (l > b)
            begin
                return 1'b0;
            end
            hist[l]++;
            if (l != 0)
            begin
                used++;
            end
        end
        if (used == 0)
        begin
            return 1'b0;
        end
        size = 1 << b;
        for (int i = 1; i <= b; i++)
        begin
            kraft += hist[i] << (b - i);
        end
        if (kraft != size)
        begin
            return 1'b0;
        end
        for (int i = 1; i <= b; i++)
        begin
            c = (c + ((i == 1) ? 0 : hist[i - 1])) << 1;
            nxt[i] = c & 16'hffff;
        end
        for (int k = 0; k < size; k++)
        begin
            dec_mem[k] = '0;
        end
        for (int s = 0; s < n; s++)
        begin
            l = int'(len_mem[s]);
            enc_mem[s] = '0;
            if (l != 0)
            begin
                r = int'(reverse_code(nxt[l], l)) & (size - 1);
                nxt[l] = (nxt[l] + 1) & 16'hffff;
                enc_mem[s] = 19'(r) | (19'(l) << 15);
                for (int k = r; k < size; k += (1 << l))
                begin
                    dec_mem[k] = slot_entry(s, l);
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic chte_out_t predict_result(chte_in_t it);
        chte_out_t   o;
        logic [23:0] e;
        int          len;
        int          x;
        int          extra;
        o = '0;
        case (it.opcode)
            OP_WRITE_LEN:
            begin
                len_mem[it.symbol] = it.code_len;
                tbl_ok = 1'b0;
            end
            OP_BUILD:
            begin
                tbl_ok = build_tables();
                if (!tbl_ok)
                begin
                    o.status = ST_REJECTED;
                end
            end
            default:
            begin
                if (!tbl_ok)
                begin
                    o.status = ST_NO_TABLE;
                end
                else if (it.opcode == OP_DECODE)
                begin
                    e = dec_mem[int'(it.bit_window) & ((1 << tbl_bits) - 1)];
                    len = int'(e[3:0]);
                    x = int'(e[7:4]);
                    extra = int'(it.bit_window >> len) & ((1 << x) - 1);
                    o.code_length = e[3:0];
                    o.decoded_value = 16'(int'(e[23:8]) + extra);
                    o.consumed_bits = 5'(len + x);
                end
                else if (int'(it.symbol) < alphabet_size())
                begin
                    o.code_bits = enc_mem[it.symbol][14:0];
                    o.code_length = enc_mem[it.symbol][18:15];
                end
            end
        endcase
        return o;
    endfunction

    always @(posedge clk)
    begin
        chte_out_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %p", $time, result);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status,
                             result.status);
                    errors++;
                end
                if (result.code_bits !== e.code_bits)
                begin
                    $display("%0t: code_bits expected %h actual %h", $time, e.code_bits,
                             result.code_bits);
                    errors++;
                end
                if (result.code_length !== e.code_length)
                begin
                    $display("%0t: code_length expected %0d actual %0d", $time,
                             e.code_length, result.code_length);
                    errors++;
                end
                if (result.decoded_value !== e.decoded_value)
                begin
                    $display("%0t: decoded_value expected %h actual %h", $time,
                             e.decoded_value, result.decoded_value);
                    errors++;
                end
                if (result.consumed_bits !== e.consumed_bits)
                begin
                    $display("%0t: consumed_bits expected %0d actual %0d", $time,
                             e.consumed_bits, result.consumed_bits);
                    errors++;
                end
            end
        end
    end

    // called at a rising edge; returns once the item is accepted and no build is running
    task automatic send_item(logic [1:0] op, logic [7:0] sym, logic [3:0] clen,
                             logic [29:0] win);
        chte_in_t it;
        it.opcode = op;
        it.symbol = sym;
        it.code_len = clen;
        it.bit_window = win;
        start <= 1'b1;
        in <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_results.push_back(predict_result(it));
        items_sent++;
        if (!calm && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TABLE_BITS:   tbl_bits = val[3:0];
            REG_SYMBOL_COUNT: sym_cnt = val[8:0];
            REG_ENTRY_KIND:   len_kind = val[0];
            default:          ;
        endcase
        if (idx != REG_UNMAPPED)
        begin
            tbl_ok = 1'b0;
        end
    endtask

    task automatic set_layout(int b, int n, int kind);
        reg_write(REG_TABLE_BITS, {$urandom} & 32'hffff_fff0 | 32'(b));
        reg_write(REG_SYMBOL_COUNT, {$urandom} & 32'hffff_fe00 | 32'(n));
        reg_write(REG_ENTRY_KIND, {$urandom} & 32'hffff_fffe | 32'(kind));
    endtask

    task automatic write_plan(int n);
        for (int s = 0; s < n; s++)
        begin
            send_item(OP_WRITE_LEN, 8'(s), 4'(plan_len[s]), 30'($urandom));
        end
    endtask

    // random complete prefix code over up to 64 of the first n symbols, lengths up to b
    task automatic make_tree(int n, int b);
        int leaves [$];
        int order [256];
        int lim;
        int idx;
        int d;
        int tmp;
        lim = (n < (1 << b)) ? n : (1 << b);
        if (lim > 64)
        begin
            lim = 64;
        end
        for (int i = 0; i < 256; i++)
        begin
            plan_len[i] = 0;
            order[i] = i;
        end
        leaves.push_back(0);
        lim = $urandom_range(2, lim);
        while (leaves.size() < lim)
        begin
            idx = $urandom_range(leaves.size() - 1);
            if (leaves[idx] < b)
            begin
                d = leaves[idx] + 1;
                leaves[idx] = d;
                leaves.push_back(d);
            end
        end
        for (int i = n - 1; i > 0; i--)
        begin
            idx = $urandom_range(i);
            tmp = order[i];
            order[i] = order[idx];
            order[idx] = tmp;
        end
        for (int i = 0; i < leaves.size(); i++)
        begin
            plan_len[order[i]] = leaves[i];
        end
    endtask

    task automatic lookups(int count, int n);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(2) != 0)
            begin
                send_item(OP_DECODE, 8'($urandom), 4'($urandom), 30'($urandom));
            end
            else if ($urandom_range(1) != 0 && n > 0)
            begin
                send_item(OP_ENCODE, 8'($urandom_range(n - 1)), 4'($urandom), 30'($urandom));
            end
            else
            begin
                send_item(OP_ENCODE, 8'($urandom), 4'($urandom), 30'($urandom));
            end
        end
    endtask

    task automatic test_no_table();
        send_item(OP_DECODE, 8'h00, 4'h0, 30'h3fff_ffff);
        send_item(OP_ENCODE, 8'hff, 4'hf, 30'h0);
        send_item(OP_WRITE_LEN, 8'hff, 4'hf, 30'h0);
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        send_item(OP_WRITE_LEN, 8'hff, 4'h0, 30'h3fff_ffff);
        // nothing has a code now
        send_item(OP_BUILD, 8'hff, 4'hf, 30'h3fff_ffff);
    endtask

    task automatic test_two_symbols();
        send_item(OP_WRITE_LEN, 8'h00, 4'h1, 30'h0);
        send_item(OP_WRITE_LEN, 8'hff, 4'h1, 30'h0);
        // only 0 and 255 coded under 9-bit width
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        send_item(OP_DECODE, 8'h00, 4'h0, 30'h0);
        send_item(OP_DECODE, 8'h00, 4'h0, 30'h3fff_ffff);
        send_item(OP_ENCODE, 8'h00, 4'h0, 30'h0);
        send_item(OP_ENCODE, 8'hff, 4'h0, 30'h0);
        send_item(OP_ENCODE, 8'h7f, 4'h0, 30'h0);
        reg_write(REG_UNMAPPED, 32'hffff_ffff);
        send_item(OP_DECODE, 8'h00, 4'h0, 30'h2aaa_aaaa);
        reg_write(REG_SYMBOL_COUNT, 32'd16);
        send_item(OP_ENCODE, 8'h00, 4'h0, 30'h0);
    endtask

    task automatic test_layout_limits();
        reg_write(REG_TABLE_BITS, 32'd0);
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        reg_write(REG_TABLE_BITS, 32'd1);
        reg_write(REG_SYMBOL_COUNT, 32'd1);
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        // count above the alphabet limit saturates
        reg_write(REG_SYMBOL_COUNT, 32'h1ff);
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        send_item(OP_ENCODE, 8'hff, 4'h0, 30'h0);
        send_item(OP_ENCODE, 8'h80, 4'h0, 30'h0);
        reg_write(REG_SYMBOL_COUNT, 32'd2);
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        send_item(OP_ENCODE, 8'h01, 4'h0, 30'h0);
    endtask

    task automatic test_length_mode();
        set_layout(15, 29, 1);
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        reg_write(REG_SYMBOL_COUNT, 32'd28);
        for (int s = 0; s < 256; s++)
        begin
            plan_len[s] = 0;
        end
        for (int i = 0; i < 15; i++)
        begin
            plan_len[12 + i] = i + 1;
        end
        plan_len[27] = 15;
        write_plan(28);
        send_item(OP_BUILD, 8'h00, 4'h0, 30'h0);
        send_item(OP_DECODE, 8'h00, 4'h0, 30'h3fff_ffff);
        send_item(OP_DECODE, 8'h00, 4'h0, 30'h0000_7fff);
        send_item(OP_DECODE, 8'h00, 4'h0, 30'h0);
        send_item(OP_ENCODE, 8'd27, 4'h0, 30'h0);
        lookups(20, 28);
    endtask

    task automatic test_random();
        int round;
        int b;
        int n;
        int eff;
        int kind;
        int big_left;
        round = 0;
        big_left = 2;
        while (items_sent < 1900)
        begin
            calm = (round >= 8 && round < 14);
            if ($urandom_range(4) != 0)
            begin
                kind = ($urandom_range(2) == 0);
                b = $urandom_range(1, 8);
                if (big_left > 0 && $urandom_range(29) == 0)
                begin
                    b = 15;
                    big_left--;
                end
                else if ($urandom_range(9) == 0)
                begin
                    b = $urandom_range(9, 12);
                end
                if (kind)
                begin
                    n = $urandom_range(2, 28);
                end
                else if ($urandom_range(11) == 0)
                begin
                    n = $urandom_range(200, 511);
                end
                else
                begin
                    n = $urandom_range(2, 40);
                end
                eff = (n > 256) ? 256 : n;
                set_layout(b, n, kind);
                make_tree(eff, b);
                if ($urandom_range(5) == 0)
                begin
                    plan_len[$urandom_range(eff - 1)] = $urandom_range(15);
                end
                write_plan(eff);
                send_item(OP_BUILD, 8'($urandom), 4'($urandom), 30'($urandom));
                lookups($urandom_range(10, 40), eff);
            end
            else
            begin
                for (int i = $urandom_range(10, 30); i > 0; i--)
                begin
                    send_item(2'($urandom), 8'($urandom), 4'($urandom), 30'($urandom));
                end
            end
            round++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        items_sent = 0;
        calm = 1'b0;
        tbl_bits = 4'd9;
        sym_cnt = 9'd256;
        len_kind = 1'b0;
        tbl_ok = 1'b0;
        for (int i = 0; i < 256; i++)
        begin
            len_mem[i] = '0;
            enc_mem[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_table();
        test_two_symbols();
        test_layout_limits();
        test_length_mode();
        test_random();
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/chte_pkg.sv
src/chte_build.sv
src/chte_tables.sv
src/canonical_huffman_table_engine.sv
tb/canonical_huffman_table_engine_tb.sv
